// File: hdl/irqd_pkg.sv
package irqd_pkg;

  localparam int unsigned NUM_LINES  = 32;
  localparam int unsigned LINE_W     = 5;
  localparam int unsigned LINE_IN_W  = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CNT_W      = 16;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd1024;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_RAISE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ENABLE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DISABLE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MASK      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SAFEPOINT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DISPATCH  = 3'd6;

  typedef enum logic [2:0] {
    OP_RAISE,
    OP_ENABLE,
    OP_DISABLE,
    OP_QUERY,
    OP_MASK,
    OP_SAFEPOINT,
    OP_DISPATCH,
    OP_NOP
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DISPATCH
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] line_bit;
    logic              bad;
    logic [WORD_W-1:0] raise_bits;
    logic              mask_value;
    logic              in_isr;
  } cmd_t;

  typedef struct packed {
    logic [LINE_W-1:0] irq_line;
    logic              dispatched;
    logic              tick_request;
    logic              reschedule;
    logic              line_enabled;
    logic              bad_line;
    logic              last;
  } res_t;

  typedef struct packed {
    logic dispatching;
    logic masked;
    logic active_any;
  } status_t;

endpackage

// File: hdl/irqd_if.sv
interface irqd_req_if;
  logic                              valid;
  logic                              ready;
  logic [irqd_pkg::KIND_W-1:0]       kind;
  logic [irqd_pkg::LINE_IN_W-1:0]    line;
  logic [irqd_pkg::WORD_W-1:0]       raise_bits;
  logic                              mask_value;
  logic                              in_isr;

  modport source (output valid, kind, line, raise_bits, mask_value, in_isr, input ready);
  modport sink   (input valid, kind, line, raise_bits, mask_value, in_isr, output ready);
endinterface

interface irqd_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [irqd_pkg::LINE_W-1:0]    irq_line;
  logic                           dispatched;
  logic                           tick_request;
  logic                           reschedule;
  logic                           line_enabled;
  logic                           bad_line;
  logic                           last;

  modport source (output valid, irq_line, dispatched, tick_request, reschedule,
                  line_enabled, bad_line, last, input ready);
  modport sink   (input valid, irq_line, dispatched, tick_request, reschedule,
                  line_enabled, bad_line, last, output ready);
endinterface

interface irqd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [irqd_pkg::CNT_W-1:0]  safepoints_per_tick;

  modport source (output valid, safepoints_per_tick, input ready);
  modport sink   (input valid, safepoints_per_tick, output ready);
endinterface

// File: hdl/irqd_front.sv
module irqd_front (
  irqd_req_if.sink       req_i,
  input  logic           full_i,
  output logic           push_o,
  output irqd_pkg::cmd_t cmd_o
);

  logic in_range;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  assign in_range = req_i.line < irqd_pkg::LINE_IN_W'(irqd_pkg::NUM_LINES);

  always_comb begin
    unique case (req_i.kind)
      irqd_pkg::KIND_RAISE:     cmd_o.op = irqd_pkg::OP_RAISE;
      irqd_pkg::KIND_ENABLE:    cmd_o.op = irqd_pkg::OP_ENABLE;
      irqd_pkg::KIND_DISABLE:   cmd_o.op = irqd_pkg::OP_DISABLE;
      irqd_pkg::KIND_QUERY:     cmd_o.op = irqd_pkg::OP_QUERY;
      irqd_pkg::KIND_MASK:      cmd_o.op = irqd_pkg::OP_MASK;
      irqd_pkg::KIND_SAFEPOINT: cmd_o.op = irqd_pkg::OP_SAFEPOINT;
      irqd_pkg::KIND_DISPATCH:  cmd_o.op = irqd_pkg::OP_DISPATCH;
      default:                  cmd_o.op = irqd_pkg::OP_NOP;
    endcase

    // Only line-addressed kinds report an out-of-range line
    case (req_i.kind) inside
      irqd_pkg::KIND_ENABLE, irqd_pkg::KIND_DISABLE, irqd_pkg::KIND_QUERY:
        cmd_o.bad = !in_range;
      default:
        cmd_o.bad = 1'b0;
    endcase

    cmd_o.line_bit   = in_range
                       ? (irqd_pkg::WORD_W'(1) << req_i.line[irqd_pkg::LINE_W-1:0])
                       : '0;
    cmd_o.raise_bits = req_i.raise_bits;
    cmd_o.mask_value = req_i.mask_value;
    cmd_o.in_isr     = req_i.in_isr;
  end

endmodule

// File: hdl/irqd_queue.sv
module irqd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  irqd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output irqd_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  irqd_pkg::cmd_t                    entry_q [irqd_pkg::QUEUE_DEPTH];
  logic [irqd_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [irqd_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [irqd_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o  = count_q == irqd_pkg::QCNT_W'(irqd_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign cmd_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + irqd_pkg::QCNT_W'(do_push) - irqd_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/irqd_back.sv
module irqd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irqd_pkg::cmd_t    cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  irqd_cfg_if.sink          cfg_i,
  irqd_rsp_if.source        rsp_o,
  output irqd_pkg::status_t status_o
);

  irqd_pkg::state_e               state_q, state_d;
  logic [irqd_pkg::WORD_W-1:0]    pending_q, pending_d;
  logic [irqd_pkg::WORD_W-1:0]    enable_q, enable_d;
  logic                           masked_q, masked_d;
  logic [irqd_pkg::CNT_W-1:0]     count_q, count_d;
  logic [irqd_pkg::CNT_W-1:0]     period_q, period_d;
  logic                           tick_hold_q, tick_hold_d;
  logic                           resched_hold_q, resched_hold_d;
  logic                           out_valid_q, out_valid_d;
  irqd_pkg::res_t                 res_q, res_d;

  logic                           slot_free;
  logic [irqd_pkg::WORD_W-1:0]    active;
  logic [irqd_pkg::WORD_W-1:0]    low_bit;
  logic [irqd_pkg::LINE_W-1:0]    low_idx;
  logic                           last_line;
  logic [irqd_pkg::CNT_W-1:0]     cnt_inc;
  logic                           tick_now;
  logic                           start_disp;

  function automatic logic [irqd_pkg::LINE_W-1:0] lowest_set(
    input logic [irqd_pkg::WORD_W-1:0] v
  );
    logic [irqd_pkg::LINE_W-1:0] idx;
    idx = '0;
    for (int i = irqd_pkg::WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = irqd_pkg::LINE_W'(i);
      end
    end
    return idx;
  endfunction

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign active    = pending_q & enable_q;
  assign low_bit   = active & (~active + 1'b1);
  assign low_idx   = lowest_set(active);
  assign last_line = (active & ~low_bit) == '0;
  assign cnt_inc   = count_q + 1'b1;
  assign tick_now  = cnt_inc >= period_q;
  assign pop_o     = (state_q == irqd_pkg::ST_IDLE) && !empty_i && slot_free;
  assign start_disp = !masked_q && (active != '0) &&
                      ((cmd_i.op == irqd_pkg::OP_DISPATCH) ||
                       (cmd_i.op == irqd_pkg::OP_SAFEPOINT));

  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.irq_line     = res_q.irq_line;
  assign rsp_o.dispatched   = res_q.dispatched;
  assign rsp_o.tick_request = res_q.tick_request;
  assign rsp_o.reschedule   = res_q.reschedule;
  assign rsp_o.line_enabled = res_q.line_enabled;
  assign rsp_o.bad_line     = res_q.bad_line;
  assign rsp_o.last         = res_q.last;

  assign status_o.dispatching = state_q == irqd_pkg::ST_DISPATCH;
  assign status_o.masked      = masked_q;
  assign status_o.active_any  = active != '0;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      irqd_pkg::ST_IDLE: begin
        if (pop_o && start_disp) begin
          state_d = irqd_pkg::ST_DISPATCH;
        end
      end
      irqd_pkg::ST_DISPATCH: begin
        if (slot_free && last_line) begin
          state_d = irqd_pkg::ST_IDLE;
        end
      end
      default: state_d = irqd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pending_d      = pending_q;
    enable_d       = enable_q;
    masked_d       = masked_q;
    count_d        = count_q;
    period_d       = cfg_i.valid ? cfg_i.safepoints_per_tick : period_q;
    tick_hold_d    = tick_hold_q;
    resched_hold_d = resched_hold_q;
    out_valid_d    = out_valid_q && !rsp_o.ready;
    res_d          = res_q;

    unique case (state_q)
      irqd_pkg::ST_IDLE: begin
        if (pop_o) begin
          res_d          = '0;
          res_d.last     = 1'b1;
          res_d.bad_line = cmd_i.bad;
          case (cmd_i.op)
            irqd_pkg::OP_RAISE:   pending_d = pending_q | cmd_i.raise_bits;
            irqd_pkg::OP_ENABLE:  enable_d  = enable_q | cmd_i.line_bit;
            irqd_pkg::OP_DISABLE: enable_d  = enable_q & ~cmd_i.line_bit;
            irqd_pkg::OP_QUERY:   res_d.line_enabled = (enable_q & cmd_i.line_bit) != '0;
            irqd_pkg::OP_MASK:    masked_d  = cmd_i.mask_value;
            irqd_pkg::OP_SAFEPOINT: begin
              count_d            = tick_now ? '0 : cnt_inc;
              res_d.tick_request = tick_now;
              res_d.reschedule   = !masked_q && (pending_q != '0) && !cmd_i.in_isr;
            end
            default: ;
          endcase
          // Hold the item's flags for every line it delivers
          tick_hold_d    = res_d.tick_request;
          resched_hold_d = res_d.reschedule;
          if (!start_disp) begin
            out_valid_d = 1'b1;
          end
        end
      end
      irqd_pkg::ST_DISPATCH: begin
        if (slot_free) begin
          res_d.irq_line     = low_idx;
          res_d.dispatched   = 1'b1;
          res_d.tick_request = tick_hold_q;
          res_d.reschedule   = resched_hold_q;
          res_d.line_enabled = 1'b0;
          res_d.bad_line     = 1'b0;
          res_d.last         = last_line;
          pending_d          = pending_q & ~low_bit;
          out_valid_d        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irqd_pkg::ST_IDLE;
      pending_q   <= '0;
      enable_q    <= '0;
      masked_q    <= 1'b1;
      count_q     <= '0;
      period_q    <= irqd_pkg::PERIOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      enable_q    <= enable_d;
      masked_q    <= masked_d;
      count_q     <= count_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_hold_q    <= tick_hold_d;
    resched_hold_q <= resched_hold_d;
    res_q          <= res_d;
  end

endmodule

// File: hdl/fixed_priority_irq_dispatcher_top.sv
// Fixed-priority interrupt dispatcher.
// req_i carries items (raise, enable, disable, query, set master mask,
// safepoint, dispatch); an item is taken on an edge with valid and ready high.
// rsp_o carries result items; each input item gives one or more results and
// the final one has last set. cfg_i writes safepoints_per_tick; write it only
// while the block is idle.
// A front stage decodes each item into a two-entry queue; a back stage owns
// the pending word, enable mask, master mask and safepoint counter and runs
// the items one at a time into a registered output slot.
// Path: an item waits in a queue entry, then in the registered output slot,
// before rsp_o shows its result; a dispatch pops its item, then sends its lines
// from the dispatch state. Throughput, while rsp_o is ready: one item per cycle
// for items that deliver no line; a dispatch holds the back stage until its last
// line, one line per cycle lowest first, set by the single priority-encode step.
// Reset: pending and enable clear, delivery is masked, the counter clears and
// safepoints_per_tick returns to 1024.
// Stall: while rsp_o is not ready the output slot holds its item, the back
// stage waits, and once the queue fills req_i drops ready.
module fixed_priority_irq_dispatcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  irqd_req_if.sink    req_i,
  irqd_rsp_if.source  rsp_o,
  irqd_cfg_if.sink    cfg_i
);

  irqd_pkg::cmd_t    front_cmd;
  irqd_pkg::cmd_t    back_cmd;
  irqd_pkg::status_t back_status;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;

  // Decode items and push them into the queue
  irqd_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  // Decouple decode from execution
  irqd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .empty_o (empty)
  );

  // Execute items against the interrupt state and emit results
  irqd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (back_cmd),
    .empty_i  (empty),
    .pop_o    (pop),
    .cfg_i    (cfg_i),
    .rsp_o    (rsp_o),
    .status_o (back_status)
  );

  // Delivery only runs while unmasked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.dispatching |-> !back_status.masked)
    else $error("dispatch running while masked");

  // A dispatch run always has a line left to deliver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.dispatching |-> back_status.active_any)
    else $error("dispatch running with nothing active");

  // Only delivered lines may be followed by more results of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.last) |-> rsp_o.dispatched)
    else $error("non-final result that delivers no line");

  // Delivery results carry no query answer or line error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.dispatched) |-> (!rsp_o.line_enabled && !rsp_o.bad_line))
    else $error("delivery result carries query or error flags");

endmodule

// File: verif/tb_fixed_priority_irq_dispatcher_top.sv
`timescale 1ns / 100ps

module tb_fixed_priority_irq_dispatcher_top;
  import irqd_pkg::*;

  // Kind 7 has no operation behind it; the block must answer it with an empty result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  // Every item can yield up to 32 results and each one may sit out a receiver stall,
  // so budget well beyond the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  logic clk_i;
  logic rst_ni;

  irqd_req_if req_if ();
  irqd_rsp_if rsp_if ();
  irqd_cfg_if cfg_if ();

  fixed_priority_irq_dispatcher_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the block's state: pending word, enable mask, master mask, safepoint
  // counter and the tick period register.
  logic [WORD_W-1:0] pend_word;
  logic [WORD_W-1:0] en_mask;
  logic              masked;
  logic [CNT_W-1:0]  sp_count;
  logic [CNT_W-1:0]  sp_period;

  // Results the block still owes, oldest first.
  res_t due_rsp_q[$];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          quiet;   // set for a stretch in which neither side idles

  // 4 ns clock: reset first, then run.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort on a hung block.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("fixed_priority_irq_dispatcher_top regression: fail");
      $finish;
    end
  end

  function automatic bit roll_idle();
    return !quiet && ($urandom_range(0, 99) < 27);
  endfunction

  // Stall the result channel at random; change ready only at the falling edge.
  always @(negedge clk_i) begin
    rsp_if.ready = rst_ni && !roll_idle();
  end

  // When unmasked, deliver every pending and enabled line, lowest first, clearing each one.
  // Return the number of result items pushed.
  function automatic int deliver_lines(logic tick, logic resched);
    logic [WORD_W-1:0] active;
    res_t              r;
    int                n;
    n = 0;
    if (masked) return 0;
    active = pend_word & en_mask;
    for (int ln = 0; ln < NUM_LINES; ln++) begin
      if (active[ln]) begin
        r              = '0;
        r.irq_line     = LINE_W'(ln);
        r.dispatched   = 1'b1;
        r.tick_request = tick;
        r.reschedule   = resched;
        // The highest active line closes the item.
        r.last         = ((active >> ln) == 1);
        pend_word[ln]  = 1'b0;
        due_rsp_q.push_back(r);
        n++;
      end
    end
    return n;
  endfunction

  // Advance the mirrored state by one accepted item and queue what it should produce.
  function automatic void dispatch_outcome(logic [KIND_W-1:0] kind,
                                           logic [LINE_IN_W-1:0] line,
                                           logic [WORD_W-1:0] bits,
                                           logic mval, logic isr);
    logic [WORD_W-1:0] lbit;
    logic              bad;
    logic              en;
    logic              tick;
    logic              resched;
    res_t              r;
    int                n;
    lbit    = (line < NUM_LINES) ? (32'd1 << line) : '0;
    bad     = (line >= NUM_LINES);
    en      = 1'b0;
    tick    = 1'b0;
    resched = 1'b0;
    n       = 0;
    case (kind)
      KIND_RAISE:   pend_word = pend_word | bits;
      KIND_ENABLE:  en_mask = en_mask | lbit;
      KIND_DISABLE: en_mask = en_mask & ~lbit;
      KIND_QUERY:   en = |(en_mask & lbit);
      KIND_MASK:    masked = mval;
      KIND_SAFEPOINT: begin
        // Count first; a counter at or past the period wraps and requests a tick.
        sp_count = sp_count + 1'b1;
        if (sp_count >= sp_period) begin
          sp_count = '0;
          tick     = 1'b1;
        end
        // Anything pending, enabled or not, enters the dispatch path when unmasked.
        if (pend_word != '0 && !masked) begin
          resched = !isr;
          n       = deliver_lines(tick, resched);
        end
      end
      KIND_DISPATCH: n = deliver_lines(1'b0, 1'b0);
      default: ;
    endcase
    if (n == 0) begin
      r              = '0;
      r.tick_request = tick;
      r.reschedule   = resched;
      r.line_enabled = en;
      r.bad_line     = bad && (kind == KIND_ENABLE || kind == KIND_DISABLE ||
                               kind == KIND_QUERY);
      r.last         = 1'b1;
      due_rsp_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each result item taken from the block against the oldest one owed.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual line %0d dispatched %0b last %0b",
                 $time, rsp_if.irq_line, rsp_if.dispatched, rsp_if.last);
        err_cnt++;
      end else begin
        want = due_rsp_q.pop_front();
        check_field("irq_line", want.irq_line, rsp_if.irq_line);
        check_field("dispatched", want.dispatched, rsp_if.dispatched);
        check_field("tick_request", want.tick_request, rsp_if.tick_request);
        check_field("reschedule", want.reschedule, rsp_if.reschedule);
        check_field("line_enabled", want.line_enabled, rsp_if.line_enabled);
        check_field("bad_line", want.bad_line, rsp_if.bad_line);
        check_field("last", want.last, rsp_if.last);
      end
    end
  end

  // Present one item, idling at random first; hold valid until it is taken.
  // Valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [LINE_IN_W-1:0] line,
                           logic [WORD_W-1:0] bits, logic mval, logic isr);
    @(negedge clk_i);
    while (roll_idle()) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.kind       = kind;
    req_if.line       = line;
    req_if.raise_bits = bits;
    req_if.mask_value = mval;
    req_if.in_isr     = isr;
    do @(posedge clk_i); while (!req_if.ready);
    dispatch_outcome(kind, line, bits, mval, isr);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the tick period; only call with the block drained.
  task automatic write_period(logic [CNT_W-1:0] period);
    @(negedge clk_i);
    cfg_if.valid               = 1'b1;
    cfg_if.safepoints_per_tick = period;
    do @(posedge clk_i); while (!cfg_if.ready);
    sp_period = period;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Right after reset: delivery masked, nothing enabled, period 1024.
  task automatic test_reset_state();
    send_item(KIND_QUERY, 8'd0, '0, 1'b0, 1'b0);
    send_item(KIND_RAISE, 8'd0, 32'h8000_0001, 1'b0, 1'b0);
    send_item(KIND_DISPATCH, 8'd0, '0, 1'b0, 1'b0);      // masked, delivers nothing
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b0);     // masked, no reschedule
    send_item(KIND_UNUSED, 8'hff, 32'hffff_ffff, 1'b1, 1'b1);
  endtask

  // Enable at both ends of the line range and past it; disable and query at its top end and past it.
  task automatic test_line_range();
    send_item(KIND_ENABLE, 8'd0, '0, 1'b0, 1'b0);
    send_item(KIND_ENABLE, 8'd31, '0, 1'b0, 1'b0);
    send_item(KIND_ENABLE, 8'd32, '0, 1'b0, 1'b0);
    send_item(KIND_ENABLE, 8'd255, '0, 1'b0, 1'b0);
    send_item(KIND_QUERY, 8'd31, '0, 1'b0, 1'b0);
    send_item(KIND_QUERY, 8'd255, '0, 1'b0, 1'b0);
    send_item(KIND_DISABLE, 8'd31, '0, 1'b0, 1'b0);
    send_item(KIND_QUERY, 8'd31, '0, 1'b0, 1'b0);
    send_item(KIND_DISABLE, 8'd200, '0, 1'b0, 1'b0);
    send_item(KIND_ENABLE, 8'd31, '0, 1'b0, 1'b0);
  endtask

  // Unmask and deliver; leave lines pending that are not enabled.
  task automatic test_delivery();
    send_item(KIND_RAISE, 8'd0, 32'hffff_ffff, 1'b0, 1'b0);
    send_item(KIND_MASK, 8'd0, '0, 1'b0, 1'b0);
    send_item(KIND_DISPATCH, 8'd0, '0, 1'b0, 1'b0);      // lines 0 and 31
    send_item(KIND_DISPATCH, 8'd0, '0, 1'b0, 1'b0);      // nothing enabled is left
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b0);     // reschedule, no delivery
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b1);     // inside a handler
    send_item(KIND_MASK, 8'd0, '0, 1'b1, 1'b0);
    send_item(KIND_RAISE, 8'd0, 32'h0000_0001, 1'b0, 1'b0);
    send_item(KIND_DISPATCH, 8'd0, '0, 1'b0, 1'b0);      // masked again
  endtask

  // Tick requests at the smallest, zero and largest periods.
  task automatic test_tick_period();
    drain();
    write_period(16'd1);
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b0);
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b1);
    drain();
    write_period(16'd0);
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b0);
    drain();
    write_period(16'hffff);
    send_item(KIND_SAFEPOINT, 8'd0, '0, 1'b0, 1'b0);
  endtask

  // One random item, weighted toward enables, safepoints and dispatches while
  // delivery mostly stays unmasked, so multi-line dispatches happen often.
  task automatic send_random_item();
    int unsigned          pick;
    logic [KIND_W-1:0]    kind;
    logic [LINE_IN_W-1:0] line;
    logic [WORD_W-1:0]    bits;
    logic                 mval;
    pick = $urandom_range(0, 99);
    if (pick < 14)      kind = KIND_RAISE;
    else if (pick < 32) kind = KIND_ENABLE;
    else if (pick < 40) kind = KIND_DISABLE;
    else if (pick < 48) kind = KIND_QUERY;
    else if (pick < 55) kind = KIND_MASK;
    else if (pick < 75) kind = KIND_SAFEPOINT;
    else if (pick < 95) kind = KIND_DISPATCH;
    else                kind = KIND_UNUSED;
    line = ($urandom_range(0, 99) < 82) ? LINE_IN_W'($urandom_range(0, NUM_LINES - 1))
                                        : LINE_IN_W'($urandom_range(NUM_LINES, 255));
    case ($urandom_range(0, 3))
      0:       bits = 32'd1 << $urandom_range(0, 31);
      1:       bits = 32'hffff_ffff;
      default: bits = $urandom();
    endcase
    mval = ($urandom_range(0, 99) < 25);
    send_item(kind, line, bits, mval, 1'($urandom_range(0, 1)));
  endtask

  // Random traffic over several tick periods, pausing for all results before
  // each period change; one phase runs with no idling on either side.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] periods[7];
    periods = '{16'd2, 16'd3, 16'd1, 16'd0, 16'hffff,
                CNT_W'($urandom_range(4, 40)), PERIOD_RESET};
    foreach (periods[p]) begin
      drain();
      write_period(periods[p]);
      quiet = (p == 2);
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk_i                      = 1'b0;
    rst_ni                     = 1'b0;
    req_if.valid               = 1'b0;
    req_if.kind                = '0;
    req_if.line                = '0;
    req_if.raise_bits          = '0;
    req_if.mask_value          = 1'b0;
    req_if.in_isr              = 1'b0;
    rsp_if.ready               = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.safepoints_per_tick = '0;
    pend_word                  = '0;
    en_mask                    = '0;
    masked                     = 1'b1;
    sp_count                   = '0;
    sp_period                  = PERIOD_RESET;
    err_cnt                    = 0;
    cycle_cnt                  = 0;
    quiet                      = 1'b0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_line_range();
    test_delivery();
    test_tick_period();
    test_random_traffic();

    // Let the last results out, then watch for anything stray before reporting.
    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("fixed_priority_irq_dispatcher_top regression: pass");
    end else begin
      $display("fixed_priority_irq_dispatcher_top regression: fail");
    end
    $finish;
  end

endmodule
